[design/dns_query_name_validator_unit_defines.svh]
// assertion macros shared by the name validator modules
`ifndef DNS_QUERY_NAME_VALIDATOR_UNIT_DEFINES_SVH
`define DNS_QUERY_NAME_VALIDATOR_UNIT_DEFINES_SVH

// condition seen at one edge implies a consequence at the next edge
`define DQNV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dqnv: next-cycle check failed");

// condition that must never hold at any edge
`define DQNV_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("dqnv: forbidden condition seen");

`endif

[design/dqnv_pkg.sv]
// shared types and constants of the dns query name validator
package dqnv_pkg;

   // verdict codes, also used as the running decision
   typedef enum logic [1:0] {
      DEC_PASS      = 2'd0,
      DEC_FORMERR   = 2'd1,
      DEC_MALFORMED = 2'd2
   } decision_type;

   // packet layout
   localparam logic [15:0] MIN_PACKET_LEN = 16'd15;
   localparam logic [15:0] NAME_START     = 16'd12;
   localparam logic [15:0] QD_HI_POS      = 16'd4;
   localparam logic [15:0] QD_LO_POS      = 16'd5;
   localparam logic [15:0] POS_MAX        = 16'hffff;

   // character codes
   localparam logic [7:0] CHAR_HYPHEN = 8'h2d;
   localparam logic [7:0] CHAR_LC_A   = 8'h61;
   localparam logic [7:0] CHAR_LC_Z   = 8'h7a;
   localparam logic [7:0] CHAR_UC_A   = 8'h41;
   localparam logic [7:0] CHAR_UC_Z   = 8'h5a;
   localparam logic [7:0] CHAR_DIG_0  = 8'h30;
   localparam logic [7:0] CHAR_DIG_9  = 8'h39;

   // one classified byte, handed from the front to the walker
   typedef struct packed {
      logic [7:0] data_byte;   // raw byte, taken as a label length
      logic       last;        // last byte of the packet
      logic       name_pos;    // position is at or past the name start
      logic       beyond;      // position is at or past the stated length
      logic       stop_len;    // zero length or length reaching the packet end
      logic       alnum;       // letter or digit
      logic       hyphen;      // hyphen
      logic       qd_bad;      // question count byte is wrong
      logic       short_bad;   // packet too short, judged on the last byte
   } q_item_type;

endpackage

[design/dqnv_front.sv]
// front end: takes packet bytes, tracks position and classifies each byte
module dqnv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,
   input  logic                  req_tlast,
   input  logic                  q_ready,
   output logic                  q_push,
   output dqnv_pkg::q_item_type  q_item
);

   logic [15:0] pos_ff;
   logic [15:0] pos_in;
   logic [7:0]  data_byte;
   logic [15:0] packet_length;
   logic [15:0] remaining;
   logic        accept;

   assign data_byte     = req_tdata[7:0];
   assign packet_length = req_tdata[23:8];
   assign req_tready    = q_ready;
   assign accept        = req_tvalid & q_ready;
   assign q_push        = accept;

   // bytes left in the packet from this position on
   assign remaining = packet_length - pos_ff;

   // byte classification
   always_comb begin
      q_item.data_byte = data_byte;
      q_item.last      = req_tlast;
      q_item.name_pos  = (pos_ff >= dqnv_pkg::NAME_START);
      q_item.beyond    = (pos_ff >= packet_length);
      q_item.stop_len  = (data_byte == 8'd0) || ({8'd0, data_byte} >= remaining);
      q_item.alnum     = ((data_byte >= dqnv_pkg::CHAR_LC_A) &&
                          (data_byte <= dqnv_pkg::CHAR_LC_Z)) ||
                         ((data_byte >= dqnv_pkg::CHAR_UC_A) &&
                          (data_byte <= dqnv_pkg::CHAR_UC_Z)) ||
                         ((data_byte >= dqnv_pkg::CHAR_DIG_0) &&
                          (data_byte <= dqnv_pkg::CHAR_DIG_9));
      q_item.hyphen    = (data_byte == dqnv_pkg::CHAR_HYPHEN);
      q_item.qd_bad    = ((pos_ff == dqnv_pkg::QD_HI_POS) && (data_byte != 8'd0)) ||
                         ((pos_ff == dqnv_pkg::QD_LO_POS) && (data_byte != 8'd1));
      q_item.short_bad = (packet_length < dqnv_pkg::MIN_PACKET_LEN) ||
                         (pos_ff < dqnv_pkg::QD_LO_POS);
   end

   // byte position, saturating, cleared after the last byte
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_tlast) begin
            pos_in = 16'd0;
         end else if (pos_ff != dqnv_pkg::POS_MAX) begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 16'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

[design/dqnv_queue.sv]
// short queue of classified bytes between front end and name walker
`include "dns_query_name_validator_unit_defines.svh"

module dqnv_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dqnv_pkg::q_item_type  push_item,
   output logic                  push_ready,
   input  logic                  pop,
   output logic                  pop_valid,
   output dqnv_pkg::q_item_type  pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

   dqnv_pkg::q_item_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `DQNV_ASSERT_NEVER(a_no_push_when_full, push && (count_ff == CNT_FULL))
   `DQNV_ASSERT_NEVER(a_no_pop_when_empty, pop && (count_ff == '0))

endmodule

[design/dqnv_back.sv]
// name walker: runs the label walk and registers the verdict word
`include "dns_query_name_validator_unit_defines.svh"

module dqnv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  dqnv_pkg::q_item_type  q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata
);

   logic [7:0]             lbl_ff;
   logic [7:0]             lbl_in;
   logic                   first_ff;
   logic                   first_in;
   logic                   done_ff;
   logic                   done_in;
   dqnv_pkg::decision_type dec_ff;
   dqnv_pkg::decision_type dec_in;
   dqnv_pkg::decision_type dec_step;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   dqnv_pkg::decision_type verdict_ff;
   dqnv_pkg::decision_type verdict_in;
   logic                   char_ok;

   // a last byte waits until the verdict register is free
   assign q_pop = q_valid && (!q_item.last || !rsp_valid_ff || rsp_tready);

   assign char_ok    = q_item.alnum || (q_item.hyphen && first_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, verdict_ff};

   // label walk and verdict
   always_comb begin
      lbl_in       = lbl_ff;
      first_in     = first_ff;
      done_in      = done_ff;
      dec_step     = dec_ff;
      dec_in       = dec_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (q_pop) begin
         if (q_item.qd_bad) begin
            dec_step = dqnv_pkg::DEC_MALFORMED;
         end
         dec_in = dec_step;
         if (!done_ff && q_item.name_pos) begin
            if (q_item.beyond) begin
               done_in = 1'b1;
            end else if (lbl_ff == 8'd0) begin
               if (q_item.stop_len) begin
                  done_in = 1'b1;
               end else begin
                  lbl_in = q_item.data_byte;
               end
            end else if (!char_ok) begin
               if (dec_step == dqnv_pkg::DEC_PASS) begin
                  dec_in = dqnv_pkg::DEC_FORMERR;
               end
               done_in = 1'b1;
            end else begin
               lbl_in = lbl_ff - 8'd1;
               if (lbl_ff == 8'd1) begin
                  first_in = 1'b0;
               end
            end
         end
         // last byte: give the verdict and start over
         if (q_item.last) begin
            if (q_item.short_bad || (dec_in == dqnv_pkg::DEC_MALFORMED)) begin
               verdict_in = dqnv_pkg::DEC_MALFORMED;
            end else begin
               verdict_in = dec_in;
            end
            rsp_valid_in = 1'b1;
            lbl_in       = 8'd0;
            first_in     = 1'b1;
            done_in      = 1'b0;
            dec_in       = dqnv_pkg::DEC_PASS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lbl_ff       <= 8'd0;
         first_ff     <= 1'b1;
         done_ff      <= 1'b0;
         dec_ff       <= dqnv_pkg::DEC_PASS;
         rsp_valid_ff <= 1'b0;
      end else begin
         lbl_ff       <= lbl_in;
         first_ff     <= first_in;
         done_ff      <= done_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // verdict payload
   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   `DQNV_ASSERT_NEXT(a_last_gives_word, q_pop && q_item.last, rsp_valid_ff)
   `DQNV_ASSERT_NEXT(a_walk_restarts, q_pop && q_item.last, (lbl_ff == 8'd0) && first_ff && !done_ff && (dec_ff == dqnv_pkg::DEC_PASS))

endmodule

[design/dns_query_name_validator_unit.sv]
// top level of the dns query name validator
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata: data_byte, packet_length; tlast: end_of_packet
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: verdict
//
// one byte per cycle sustained while verdicts are taken; the front end registers each classified byte
// into a two-entry queue and the walker retires one byte a cycle from it.
// the verdict word is registered when the walker takes the last byte of a packet from the queue.
// a stalled verdict holds the walker only when the next packet's last byte
// reaches it; the queue then fills and req_tready drops.
// reset is synchronous, active high, and clears position, walk state and queue.
module dns_query_name_validator_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] data_byte, [23:8] packet_length
   input  logic        req_tlast,   // end_of_packet
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] verdict, [7:2] zero
);

   logic                 q_push;
   logic                 q_ready;
   dqnv_pkg::q_item_type q_push_item;
   logic                 q_pop;
   logic                 q_valid;
   dqnv_pkg::q_item_type q_pop_item;

   // byte intake and classification
   dqnv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   // decoupling queue
   dqnv_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (q_pop_item)
   );

   // label walk and verdict output
   dqnv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[tb/sv/tb_dns_query_name_validator_unit.sv]
// self-checking testbench of the dns query name validator top level
`timescale 1ns / 1ps

module tb_dns_query_name_validator_unit;

   typedef logic [7:0] byte_q_type [$];

   localparam int CYCLE_LIMIT   = 600000;
   localparam int WORDS_PER_RUN = 285;
   localparam logic [7:0] QD_HI_OK = 8'h00;
   localparam logic [7:0] QD_LO_OK = 8'h01;

   // running verdict predictor and the queue of verdicts still owed by the block
   class verdict_scoreboard;
      dqnv_pkg::decision_type verdicts_owed [$];
      logic [15:0]            byte_pos;
      logic [7:0]             label_left;
      logic                   first_label;
      logic                   walk_over;
      dqnv_pkg::decision_type running;
      int                     mismatches;
      int                     verdicts_checked;
      int                     predicted [3];

      function new();
         restart();
         mismatches = 0;
         verdicts_checked = 0;
         predicted = '{0, 0, 0};
      endfunction

      function void restart();
         byte_pos    = '0;
         label_left  = '0;
         first_label = 1'b1;
         walk_over   = 1'b0;
         running     = dqnv_pkg::DEC_PASS;
      endfunction

      function bit label_char_ok(logic [7:0] c, logic first);
         if (c >= dqnv_pkg::CHAR_LC_A && c <= dqnv_pkg::CHAR_LC_Z) return 1'b1;
         if (c >= dqnv_pkg::CHAR_UC_A && c <= dqnv_pkg::CHAR_UC_Z) return 1'b1;
         if (c >= dqnv_pkg::CHAR_DIG_0 && c <= dqnv_pkg::CHAR_DIG_9) return 1'b1;
         if (c == dqnv_pkg::CHAR_HYPHEN) return first;
         return 1'b0;
      endfunction

      // advance the walk by one accepted packet byte
      function void note_byte(logic [7:0] b, logic [15:0] len, logic last);
         logic [15:0]            p;
         dqnv_pkg::decision_type v;
         p = byte_pos;
         if ((p == dqnv_pkg::QD_HI_POS && b != QD_HI_OK) ||
             (p == dqnv_pkg::QD_LO_POS && b != QD_LO_OK))
            running = dqnv_pkg::DEC_MALFORMED;
         // name walk from the name start
         if (!walk_over && p >= dqnv_pkg::NAME_START) begin
            if (p >= len) begin
               walk_over = 1'b1;
            end else if (label_left == 8'd0) begin
               if (b == 8'd0 || {8'd0, b} >= len - p) walk_over = 1'b1;
               else label_left = b;
            end else if (!label_char_ok(b, first_label)) begin
               if (running == dqnv_pkg::DEC_PASS) running = dqnv_pkg::DEC_FORMERR;
               walk_over = 1'b1;
            end else begin
               label_left = label_left - 8'd1;
               if (label_left == 8'd0) first_label = 1'b0;
            end
         end
         if (byte_pos != dqnv_pkg::POS_MAX) byte_pos = byte_pos + 16'd1;
         // verdict on the last byte
         if (last) begin
            if (len < dqnv_pkg::MIN_PACKET_LEN || p < dqnv_pkg::QD_LO_POS ||
                running == dqnv_pkg::DEC_MALFORMED)
               v = dqnv_pkg::DEC_MALFORMED;
            else
               v = running;
            verdicts_owed.push_back(v);
            predicted[v]++;
            restart();
         end
      endfunction

      function void report(string what, logic [7:0] exp_word, logic [7:0] got_word);
         if (mismatches < 10)
            $display("mismatch: %s expected %02h got %02h", what, exp_word, got_word);
         mismatches++;
      endfunction

      // compare one accepted verdict word with the oldest owed verdict
      function void check_verdict(logic [7:0] word);
         dqnv_pkg::decision_type exp_v;
         if (verdicts_owed.size() == 0) begin
            report("verdict word with none owed,", 8'h00, word);
         end else begin
            exp_v = verdicts_owed.pop_front();
            verdicts_checked++;
            if (word !== {6'd0, exp_v}) report("verdict", {6'd0, exp_v}, word);
         end
      endfunction

      function int pending();
         return verdicts_owed.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   verdict_scoreboard sb = new();
   int  src_idle_pct   = 0;
   int  sink_stall_pct = 0;
   logic sink_hold     = 1'b0;
   int  cycles         = 0;
   int  words_sent     = 0;
   int  packets_sent   = 0;

   dns_query_name_validator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] data_byte, [23:8] packet_length
      .req_tlast  (req_tlast),   // end_of_packet
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [1:0] verdict, [7:2] zero
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // monitor both channels and drive the receiver side
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_verdict(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_byte(req_tdata[7:0], req_tdata[23:8], req_tlast);
      end
      rsp_tready <= !sink_hold && ($urandom_range(0, 99) >= sink_stall_pct);
   end

   // cycle counter that ends a hung run
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d verdicts owed", cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
   end

   // offer one word and wait for it to be taken
   task automatic send_word(input logic [7:0] b, input logic [15:0] len, input logic last);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, b};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // stream one packet, the stated length switching at change_at if it is in range
   task automatic send_packet(input byte_q_type pkt, input logic [15:0] len_first,
                              input int change_at, input logic [15:0] len_later);
      for (int i = 0; i < pkt.size(); i++)
         send_word(pkt[i], (change_at >= 0 && i >= change_at) ? len_later : len_first,
                   i == pkt.size() - 1);
      packets_sent++;
   endtask

   // drop valid and hold until every owed verdict has come
   task automatic wait_verdicts_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic void put_header(ref byte_q_type q, input logic [7:0] hi,
                                      input logic [7:0] lo);
      for (int i = 0; i < 12; i++)
         q.push_back(i == 4 ? hi : i == 5 ? lo : 8'($urandom_range(0, 255)));
   endfunction

   function automatic void put_label(ref byte_q_type q, input string s);
      q.push_back(8'(s.len()));
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   function automatic void put_tail(ref byte_q_type q);
      for (int i = 0; i < 4; i++) q.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [7:0] pick_good_char();
      case ($urandom_range(0, 2))
         0:       return dqnv_pkg::CHAR_LC_A + 8'($urandom_range(0, 25));
         1:       return dqnv_pkg::CHAR_UC_A + 8'($urandom_range(0, 25));
         default: return dqnv_pkg::CHAR_DIG_0 + 8'($urandom_range(0, 9));
      endcase
   endfunction

   // mostly the neighbors of the accepted character ranges
   function automatic logic [7:0] pick_bad_char();
      case ($urandom_range(0, 7))
         0:       return dqnv_pkg::CHAR_LC_A - 8'd1;
         1:       return dqnv_pkg::CHAR_LC_Z + 8'd1;
         2:       return dqnv_pkg::CHAR_UC_A - 8'd1;
         3:       return dqnv_pkg::CHAR_UC_Z + 8'd1;
         4:       return dqnv_pkg::CHAR_DIG_0 - 8'd1;
         5:       return dqnv_pkg::CHAR_DIG_9 + 8'd1;
         6:       return 8'h5f;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one random packet: mostly well-formed queries, some truncated, some noise
   task automatic build_random_packet(output byte_q_type pkt, output logic [15:0] len_first,
                                      output int change_at, output logic [15:0] len_later);
      int kind;
      int n;
      int r;
      int label_len;
      pkt = {};
      kind = $urandom_range(0, 99);
      change_at = -1;
      len_later = '0;
      if (kind < 15) begin
         n = $urandom_range(1, 40);
         for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
         len_first = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'(n);
      end else begin
         if ($urandom_range(0, 99) < 5)
            put_header(pkt, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         else
            put_header(pkt, QD_HI_OK, QD_LO_OK);
         n = $urandom_range(1, 4);
         for (int l = 0; l < n; l++) begin
            label_len = ($urandom_range(0, 99) < 3) ? $urandom_range(13, 70)
                                                    : $urandom_range(1, 12);
            pkt.push_back(8'(label_len));
            for (int c = 0; c < label_len; c++) begin
               r = $urandom_range(0, 999);
               if (r < 15)      pkt.push_back(pick_bad_char());
               else if (r < 80) pkt.push_back(dqnv_pkg::CHAR_HYPHEN);
               else             pkt.push_back(pick_good_char());
            end
         end
         if ($urandom_range(0, 9) != 0) pkt.push_back(8'h00);
         put_tail(pkt);
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
         n = pkt.size();
         // truncated query with the full length still stated
         if (kind >= 85) pkt = pkt[0:$urandom_range(0, n - 1)];
         r = $urandom_range(0, 99);
         if (r < 78)      len_first = 16'(n);
         else if (r < 88) len_first = 16'($urandom_range(0, n));
         else if (r < 94) len_first = 16'(n + $urandom_range(1, 20));
         else             len_first = 16'($urandom_range(0, 65535));
      end
      if ($urandom_range(0, 99) < 6) begin
         change_at = $urandom_range(0, pkt.size() - 1);
         len_later = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, pkt.size() + 4));
      end
   endtask

   // hold the receiver off for a long stretch in a process of its own
   task automatic squeeze_input();
      byte_q_type pkt;
      fork
         begin
            @(posedge clock);
            sink_hold <= 1'b1;
            repeat (400) @(posedge clock);
            sink_hold <= 1'b0;
         end
      join_none
      for (int k = 0; k < 30; k++) begin
         pkt = {};
         for (int i = 0; i < 4; i++) pkt.push_back(8'($urandom_range(0, 255)));
         send_packet(pkt, 16'($urandom_range(0, 65535)), -1, '0);
      end
      wait_verdicts_done();
   endtask

   // directed packets covering each named special case
   task automatic run_directed();
      byte_q_type pkt;
      // plain query
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); put_label(pkt, "abc"); put_label(pkt, "Z09");
      pkt.push_back(8'h00); put_tail(pkt); send_packet(pkt, 16'(pkt.size()), -1, '0);
      // range edges and a hyphen in the first label
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); put_label(pkt, "azAZ09-");
      put_label(pkt, "mM5");
      pkt.push_back(8'h00); put_tail(pkt); send_packet(pkt, 16'(pkt.size()), -1, '0);
      // hyphen in a later label
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); put_label(pkt, "ab"); put_label(pkt, "c-d");
      pkt.push_back(8'h00); put_tail(pkt); send_packet(pkt, 16'(pkt.size()), -1, '0);
      // bad character, then an all-ones byte inside a label
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); put_label(pkt, "a_b");
      pkt.push_back(8'h00); put_tail(pkt); send_packet(pkt, 16'(pkt.size()), -1, '0);
      pkt = {}; put_header(pkt, 8'hff, 8'hff); pkt[4] = QD_HI_OK; pkt[5] = QD_LO_OK;
      pkt.push_back(8'd2); pkt.push_back(8'hff); pkt.push_back(8'h61);
      pkt.push_back(8'h00); put_tail(pkt); send_packet(pkt, 16'(pkt.size()), -1, '0);
      // too short by one byte
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); pkt.push_back(8'h00); pkt.push_back(8'h01);
      send_packet(pkt, 16'(pkt.size()), -1, '0);
      // wrong question count high and low byte
      pkt = {}; put_header(pkt, 8'h01, QD_LO_OK); put_label(pkt, "ok");
      pkt.push_back(8'h00); put_tail(pkt); send_packet(pkt, 16'(pkt.size()), -1, '0);
      pkt = {}; put_header(pkt, QD_HI_OK, 8'h02); put_label(pkt, "ok");
      pkt.push_back(8'h00); put_tail(pkt); send_packet(pkt, 16'(pkt.size()), -1, '0);
      // malformed wins over a bad name
      pkt = {}; put_header(pkt, 8'h80, QD_LO_OK); put_label(pkt, "a{b");
      pkt.push_back(8'h00); put_tail(pkt); send_packet(pkt, 16'(pkt.size()), -1, '0);
      // packet ends before the question count is complete
      pkt = {8'h00, 8'h00, 8'h00, 8'h00}; send_packet(pkt, 16'd30, -1, '0);
      pkt = {8'h00}; send_packet(pkt, 16'd0, -1, '0);
      // label length reaching the packet end
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); pkt.push_back(8'd200);
      for (int i = 0; i < 12; i++) pkt.push_back(8'h25);
      send_packet(pkt, 16'(pkt.size()), -1, '0);
      // stated length shorter than the bytes sent
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); put_label(pkt, "abc");
      for (int i = 0; i < 10; i++) pkt.push_back(8'h2e);
      send_packet(pkt, 16'd16, -1, '0);
      // packet ends inside a label
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); pkt.push_back(8'd10);
      pkt.push_back(8'h61); pkt.push_back(8'h62); send_packet(pkt, 16'd40, -1, '0);
      // length changes within the packet: short on the last byte, then cut mid-name
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); put_label(pkt, "abcd");
      send_packet(pkt, 16'd40, pkt.size() - 1, 16'd10);
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); put_label(pkt, "abc_x");
      pkt.push_back(8'h00); send_packet(pkt, 16'd40, 15, 16'd15);
      // largest stated length, and a longest label that runs out early
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); put_label(pkt, "q");
      pkt.push_back(8'h00); put_tail(pkt); send_packet(pkt, 16'hffff, -1, '0);
      pkt = {}; put_header(pkt, QD_HI_OK, QD_LO_OK); pkt.push_back(8'd255);
      pkt.push_back(8'h5a); pkt.push_back(8'h39); send_packet(pkt, 16'hffff, -1, '0);
      wait_verdicts_done();
   endtask

   // main sequence
   initial begin
      byte_q_type  pkt;
      logic [15:0] len_first;
      logic [15:0] len_later;
      int          change_at;
      int          target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      squeeze_input();
      // random phases: no idling, sender idle, receiver stalling, both
      for (int ph = 0; ph < 4; ph++) begin
         src_idle_pct   = (ph == 1) ? 74 : (ph == 3) ? 18 : 0;
         sink_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 18 : 0;
         target = words_sent + WORDS_PER_RUN;
         while (words_sent < target) begin
            build_random_packet(pkt, len_first, change_at, len_later);
            send_packet(pkt, len_first, change_at, len_later);
         end
         wait_verdicts_done();
      end
      repeat (10) @(posedge clock);
      $display("covered %0d packets in %0d bytes, %0d verdicts checked",
               packets_sent, words_sent, sb.verdicts_checked);
      $display("pass %0d, format error %0d, malformed %0d; idle mixes and a long hold; %0d mismatches",
               sb.predicted[dqnv_pkg::DEC_PASS], sb.predicted[dqnv_pkg::DEC_FORMERR],
               sb.predicted[dqnv_pkg::DEC_MALFORMED], sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/dqnv_pkg.sv
design/dqnv_front.sv
design/dqnv_queue.sv
design/dqnv_back.sv
design/dns_query_name_validator_unit.sv
tb/sv/tb_dns_query_name_validator_unit.sv
